FILE: sv/cosine_similarity_unit_assert.svh
// assertion macros used by the top-level rtl file
`ifndef COSINE_SIMILARITY_UNIT_ASSERT_SVH
`define COSINE_SIMILARITY_UNIT_ASSERT_SVH

// same-cycle implication
`define CSU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csu assertion failed");

// next-cycle implication
`define CSU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csu assertion failed");

`endif

FILE: sv/csu_pkg.sv
// ----------------------------------------------------------------------------
// csu_pkg
// types and constants of the cosine similarity unit
// ----------------------------------------------------------------------------
`default_nettype none

package csu_pkg;

  localparam int LANES  = 4;
  localparam int ELEM_W = 16;
  localparam int CNT_W  = 3;
  localparam int DOT_W  = 44;
  localparam int SQ_W   = 43;
  localparam int PROD_W = 2 * SQ_W;
  localparam int NUM_W  = DOT_W + 15;
  localparam int SIM_W  = 16;
  localparam int STEP_W = 6;

  typedef enum logic [2:0] {
    FIN_IDLE,
    FIN_MUL,
    FIN_SQRT,
    FIN_DIV,
    FIN_DONE
  } fin_state_t;

  typedef struct packed {
    logic signed [31:0] ab;
    logic [30:0]        aa;
    logic [30:0]        bb;
  } lane_prod_t;

  typedef struct packed {
    logic                    start;
    logic signed [DOT_W-1:0] dot;
    logic [SQ_W-1:0]         sq_a;
    logic [SQ_W-1:0]         sq_b;
    logic                    ovf;
  } fin_req_t;

  typedef struct packed {
    logic             valid;
    logic             idle;
    logic [SIM_W-1:0] sim;
    logic             zero;
    logic             ovf;
  } fin_rsp_t;

endpackage

`default_nettype wire

FILE: sv/csu_lane.sv
// ----------------------------------------------------------------------------
// csu_lane
// one lane: registered products of an element pair
// ----------------------------------------------------------------------------
`default_nettype none

module csu_lane
  import csu_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [ELEM_W-1:0] a,
  input  wire logic signed [ELEM_W-1:0] b,
  input  wire logic                     active,
  output lane_prod_t                    prod
);

  logic signed [31:0] ab;
  logic signed [31:0] aa;
  logic signed [31:0] bb;

  assign ab = a * b;
  assign aa = a * a;
  assign bb = b * b;

  always_ff @(posedge clk) begin
    if (active) begin
      prod.ab <= ab;
      prod.aa <= aa[30:0];
      prod.bb <= bb[30:0];
    end else begin
      prod <= '0;
    end
  end

endmodule

`default_nettype wire

FILE: sv/csu_accum.sv
// ----------------------------------------------------------------------------
// csu_accum
// merges the lane products into saturating accumulators
// ----------------------------------------------------------------------------
`default_nettype none

module csu_accum
  import csu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_last,
  input  wire lane_prod_t prods [LANES],
  output fin_req_t        req
);

  logic signed [DOT_W-1:0] dot_sum;
  logic [SQ_W-1:0]         sumsq_first;
  logic [SQ_W-1:0]         sumsq_second;
  logic                    saturated_flag;

  logic signed [33:0]      dpart;
  logic [32:0]             apart;
  logic [32:0]             bpart;
  logic [DOT_W:0]          nd;
  logic [SQ_W:0]           na;
  logic [SQ_W:0]           nb;
  logic signed [DOT_W-1:0] dot_next;
  logic [SQ_W-1:0]         sqa_next;
  logic [SQ_W-1:0]         sqb_next;
  logic                    sat_now;

  always_comb begin
    dpart = '0;
    apart = '0;
    bpart = '0;
    for (int k = 0; k < LANES; k++) begin
      dpart = dpart + {{2{prods[k].ab[31]}}, prods[k].ab};
      apart = apart + {2'b00, prods[k].aa};
      bpart = bpart + {2'b00, prods[k].bb};
    end
    nd = {dot_sum[DOT_W-1], dot_sum} + {{(DOT_W-33){dpart[33]}}, dpart};
    na = {1'b0, sumsq_first} + {{(SQ_W-32){1'b0}}, apart};
    nb = {1'b0, sumsq_second} + {{(SQ_W-32){1'b0}}, bpart};
    sat_now = 1'b0;
    if (nd[DOT_W] != nd[DOT_W-1]) begin
      sat_now  = 1'b1;
      dot_next = nd[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
    end else begin
      dot_next = nd[DOT_W-1:0];
    end
    if (na[SQ_W]) begin
      sat_now  = 1'b1;
      sqa_next = '1;
    end else begin
      sqa_next = na[SQ_W-1:0];
    end
    if (nb[SQ_W]) begin
      sat_now  = 1'b1;
      sqb_next = '1;
    end else begin
      sqb_next = nb[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum        <= '0;
      sumsq_first    <= '0;
      sumsq_second   <= '0;
      saturated_flag <= 1'b0;
      req.start      <= 1'b0;
    end else begin
      req.start <= in_valid && in_last;
      if (in_valid) begin
        if (in_last) begin
          dot_sum        <= '0;
          sumsq_first    <= '0;
          sumsq_second   <= '0;
          saturated_flag <= 1'b0;
        end else begin
          dot_sum        <= dot_next;
          sumsq_first    <= sqa_next;
          sumsq_second   <= sqb_next;
          saturated_flag <= saturated_flag | sat_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_last) begin
      req.dot  <= dot_next;
      req.sq_a <= sqa_next;
      req.sq_b <= sqb_next;
      req.ovf  <= saturated_flag | sat_now;
    end
  end

endmodule

`default_nettype wire

FILE: sv/csu_finalise.sv
// ----------------------------------------------------------------------------
// csu_finalise
// bit-serial multiply, square root and divide giving the clipped quotient
// ----------------------------------------------------------------------------
`default_nettype none

module csu_finalise
  import csu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire fin_req_t req,
  input  wire logic     take,
  output fin_rsp_t      rsp
);

  fin_state_t state;
  fin_state_t state_next;

  logic [STEP_W-1:0] step;
  logic [PROD_W-1:0] mcand;
  logic [SQ_W-1:0]   mplier;
  logic [PROD_W-1:0] prod;
  logic [SQ_W+1:0]   rem;
  logic [SQ_W-1:0]   root;
  logic [NUM_W-1:0]  dvd;
  logic [DOT_W-1:0]  drem;
  logic [NUM_W-1:0]  quo;
  logic              neg;
  logic              zero;
  logic              ovf;

  logic [SQ_W+3:0]   rem_t;
  logic [SQ_W+3:0]   trial;
  logic [DOT_W:0]    drem_t;
  logic [DOT_W-1:0]  dot_abs;
  logic              is_zero;

  assign rem_t   = {rem, prod[PROD_W-1 -: 2]};
  assign trial   = {2'b00, root, 2'b01};
  assign drem_t  = {drem, dvd[NUM_W-1]};
  assign dot_abs = req.dot[DOT_W-1] ? DOT_W'(-req.dot) : DOT_W'(req.dot);
  assign is_zero = (req.sq_a == '0) || (req.sq_b == '0);

  always_comb begin
    state_next = state;
    unique case (state)
      FIN_IDLE: if (req.start) state_next = is_zero ? FIN_DONE : FIN_MUL;
      FIN_MUL:  if (step == STEP_W'(SQ_W - 1)) state_next = FIN_SQRT;
      FIN_SQRT: if (step == STEP_W'(SQ_W - 1)) state_next = FIN_DIV;
      FIN_DIV:  if (step == STEP_W'(NUM_W - 1)) state_next = FIN_DONE;
      FIN_DONE: if (take) state_next = FIN_IDLE;
      default:  state_next = FIN_IDLE;
    endcase
  end

  always_comb begin
    rsp.valid = (state == FIN_DONE);
    rsp.idle  = (state == FIN_IDLE);
    rsp.zero  = zero;
    rsp.ovf   = ovf;
    if (zero) begin
      rsp.sim = '0;
    end else if (!neg) begin
      rsp.sim = (quo > NUM_W'(32767)) ? SIM_W'(32767) : quo[SIM_W-1:0];
    end else begin
      rsp.sim = (quo > NUM_W'(32768)) ? SIM_W'(32768) : SIM_W'(-quo[SIM_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FIN_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= (state != state_next) ? '0 : step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      FIN_IDLE: begin
        if (req.start) begin
          mcand  <= {{(PROD_W-SQ_W){1'b0}}, req.sq_a};
          mplier <= req.sq_b;
          prod   <= '0;
          rem    <= '0;
          root   <= '0;
          drem   <= '0;
          quo    <= '0;
          dvd    <= {dot_abs, 15'b0};
          neg    <= req.dot[DOT_W-1];
          zero   <= is_zero;
          ovf    <= req.ovf;
        end
      end
      FIN_MUL: begin
        if (mplier[0]) prod <= prod + mcand;
        mcand  <= {mcand[PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[SQ_W-1:1]};
      end
      FIN_SQRT: begin
        prod <= {prod[PROD_W-3:0], 2'b00};
        if (rem_t >= trial) begin
          rem  <= (SQ_W+2)'(rem_t - trial);
          root <= {root[SQ_W-2:0], 1'b1};
        end else begin
          rem  <= rem_t[SQ_W+1:0];
          root <= {root[SQ_W-2:0], 1'b0};
        end
      end
      FIN_DIV: begin
        dvd <= {dvd[NUM_W-2:0], 1'b0};
        if (drem_t >= {2'b00, root}) begin
          drem <= DOT_W'(drem_t - {2'b00, root});
          quo  <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          drem <= drem_t[DOT_W-1:0];
          quo  <= {quo[NUM_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/cosine_similarity_unit.sv
// ----------------------------------------------------------------------------
// cosine_similarity_unit
// streaming cosine similarity of two q2.14 vectors, q1.15 result
// ----------------------------------------------------------------------------
// Items carrying up to four element pairs are taken one per cycle while a
// vector pair is being accumulated. After the transfer marked tlast the
// unit takes no item until that pair's result sits in the output register:
// the pair passes two pipeline stages, then a bit-serial 43-step multiply,
// 43-step square root and 59-step divide in the finalise unit, which skips
// all three when either vector has zero magnitude. The output register
// lets accumulation of the next pair go on while a result waits.
`default_nettype none
`include "cosine_similarity_unit_assert.svh"

module cosine_similarity_unit
  import csu_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // a_elem0..a_elem3, b_elem0..b_elem3
  input  wire logic [8*ELEM_W-1:0] s_tdata,
  // valid_count
  input  wire logic [CNT_W-1:0]    s_tuser,
  input  wire logic                s_tlast,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // similarity
  output logic [SIM_W-1:0]         m_tdata,
  // zero_norm, overflow
  output logic [1:0]               m_tuser
);

  logic       accept;
  logic       pend;
  logic       s1_valid;
  logic       s1_last;
  logic       take;
  lane_prod_t prods [LANES];
  fin_req_t   req;
  fin_rsp_t   rsp;

  assign s_tready = !pend;
  assign accept   = s_tvalid && s_tready;
  assign take     = rsp.valid && (!m_tvalid || m_tready);

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    csu_lane u_lane (
      .clk    (clk),
      .a      (s_tdata[k*ELEM_W +: ELEM_W]),
      .b      (s_tdata[(k+LANES)*ELEM_W +: ELEM_W]),
      .active (s_tuser > CNT_W'(k)),
      .prod   (prods[k])
    );
  end

  csu_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .in_last  (s1_last),
    .prods    (prods),
    .req      (req)
  );

  csu_finalise u_finalise (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .take (take),
    .rsp  (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s1_last  <= accept && s_tlast;
      if (accept && s_tlast) pend <= 1'b1;
      else if (take) pend <= 1'b0;
      if (take) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= rsp.sim;
      m_tuser <= {rsp.ovf, rsp.zero};
    end
  end

  `CSU_ASSERT_IMP(a_start_idle, req.start, rsp.idle)
  `CSU_ASSERT_IMP(a_take_pend, take, pend)
  `CSU_ASSERT_IMP(a_zero_sim, m_tvalid && m_tuser[0], m_tdata == '0)
  `CSU_ASSERT_NXT(a_last_blocks, accept && s_tlast, !s_tready)

endmodule

`default_nettype wire

FILE: tb/sv/cosine_similarity_unit_test.sv
// ----------------------------------------------------------------------------
// cosine_similarity_unit_test
// self-checking testbench of the cosine similarity unit
// ----------------------------------------------------------------------------
// Element pairs are streamed in vector pairs with random gaps on both sides.
// An exact integer model of the accumulators, the square root and the divide
// predicts each result. Stimulus covers element extremes, zero magnitude,
// clipping and out-of-range lane counts.
`default_nettype none

module cosine_similarity_unit_test;
  import csu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [SIM_W-1:0] sim;
    logic             zero;
    logic             ovf;
  } sim_result_t;

  class similarity_tracker;
    longint          dot_acc;
    longint unsigned sq_a_acc;
    longint unsigned sq_b_acc;
    bit              sat;
    sim_result_t     pending[$];
    int              fails;

    function new();
      dot_acc  = 0;
      sq_a_acc = 0;
      sq_b_acc = 0;
      sat      = 0;
      fails    = 0;
    endfunction

    // one accepted transfer on the input side
    function void take_item(logic [8*ELEM_W-1:0] data, logic [CNT_W-1:0] cnt,
                            logic last);
      longint          dmax, dmin, a, b, dpart, q;
      longint unsigned sqmax, apart, bpart;
      int              n;
      logic [85:0]     prod, c86;
      logic [42:0]     root, c;
      sim_result_t     res;
      dmax  = (64'sd1 <<< 43) - 1;
      dmin  = -dmax - 1;
      sqmax = (64'd1 << 43) - 1;
      n     = (cnt > LANES) ? LANES : int'(cnt);
      dpart = 0;
      apart = 0;
      bpart = 0;
      for (int k = 0; k < n; k++) begin
        a = longint'($signed(data[k*ELEM_W +: ELEM_W]));
        b = longint'($signed(data[(k+LANES)*ELEM_W +: ELEM_W]));
        dpart += a * b;
        apart += longint'(a * a);
        bpart += longint'(b * b);
      end
      dot_acc += dpart;
      if (dot_acc > dmax) begin
        dot_acc = dmax;
        sat = 1;
      end
      if (dot_acc < dmin) begin
        dot_acc = dmin;
        sat = 1;
      end
      sq_a_acc += apart;
      if (sq_a_acc > sqmax) begin
        sq_a_acc = sqmax;
        sat = 1;
      end
      sq_b_acc += bpart;
      if (sq_b_acc > sqmax) begin
        sq_b_acc = sqmax;
        sat = 1;
      end
      if (!last) return;
      res.sim  = '0;
      res.zero = 0;
      res.ovf  = sat;
      if (sq_a_acc == 0 || sq_b_acc == 0) begin
        res.zero = 1;
      end else begin
        prod = 86'(sq_a_acc) * 86'(sq_b_acc);
        root = '0;
        for (int bit_i = 42; bit_i >= 0; bit_i--) begin
          c   = root | (43'd1 << bit_i);
          c86 = c;
          if (c86 * c86 <= prod) root = c;
        end
        q = (dot_acc * 32768) / longint'({21'd0, root});
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        res.sim = q[15:0];
      end
      pending.push_back(res);
      dot_acc  = 0;
      sq_a_acc = 0;
      sq_b_acc = 0;
      sat      = 0;
    endfunction

    // one accepted transfer on the output side
    function void check_result(logic [SIM_W-1:0] sim, logic zero, logic ovf);
      sim_result_t exp_res;
      if (pending.size() == 0) begin
        $error("unexpected result: similarity %0d", $signed(sim));
        fails++;
        return;
      end
      exp_res = pending.pop_front();
      if (sim !== exp_res.sim) begin
        $error("similarity: expected %0d, got %0d", $signed(exp_res.sim), $signed(sim));
        fails++;
      end
      if (zero !== exp_res.zero) begin
        $error("zero_norm: expected %0b, got %0b", exp_res.zero, zero);
        fails++;
      end
      if (ovf !== exp_res.ovf) begin
        $error("overflow: expected %0b, got %0b", exp_res.ovf, ovf);
        fails++;
      end
    endfunction
  endclass

  logic                clk = 0;
  logic                rst = 1;
  logic                s_tvalid = 0;
  logic                s_tready;
  logic [8*ELEM_W-1:0] s_tdata = '0;
  logic [CNT_W-1:0]    s_tuser = '0;
  logic                s_tlast = 0;
  logic                m_tvalid;
  logic                m_tready = 0;
  logic [SIM_W-1:0]    m_tdata;
  logic [1:0]          m_tuser;

  similarity_tracker tracker = new();
  bit                no_idle = 0;

  always #1 clk = ~clk;

  cosine_similarity_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) tracker.take_item(s_tdata, s_tuser, s_tlast);
      if (m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser[0], m_tuser[1]);
    end
  end

  // output side back-pressure
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 0;
    end else begin
      stall_left <= gap_len();
      m_tready   <= 1;
    end
  end

  task automatic send_item(logic [8*ELEM_W-1:0] data, logic [CNT_W-1:0] cnt,
                           logic last);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= data;
    s_tuser  <= cnt;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [ELEM_W-1:0] rand_elem(int style);
    int r;
    r = $urandom_range(0, 9);
    case (style)
      0: return ELEM_W'($urandom());
      1: return ELEM_W'($signed($urandom_range(0, 64)) - 32);
      default: begin
        if (r < 4) return 16'h8000;
        if (r < 8) return 16'h7fff;
        return ELEM_W'($urandom());
      end
    endcase
  endfunction

  // random vector pair: style of content, optional zero side, optional b tied to a
  task automatic send_pair(int len);
    logic [8*ELEM_W-1:0] data;
    logic [CNT_W-1:0]    cnt;
    logic [ELEM_W-1:0]   a;
    int style, zero_side, tie;
    style     = $urandom_range(0, 5) < 4 ? 0 : $urandom_range(1, 2);
    zero_side = $urandom_range(0, 11);
    tie       = $urandom_range(0, 5);
    for (int i = 0; i < len; i++) begin
      for (int k = 0; k < LANES; k++) begin
        a = (zero_side == 0) ? '0 : rand_elem(style);
        data[k*ELEM_W +: ELEM_W] = a;
        if (zero_side == 1) data[(k+LANES)*ELEM_W +: ELEM_W] = '0;
        else if (tie == 0) data[(k+LANES)*ELEM_W +: ELEM_W] = a;
        else if (tie == 1) data[(k+LANES)*ELEM_W +: ELEM_W] = -a;
        else data[(k+LANES)*ELEM_W +: ELEM_W] = rand_elem(style);
      end
      cnt = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(0, 7))
                                        : CNT_W'($urandom_range(1, 4));
      send_item(data, cnt, i == len - 1);
    end
  endtask

  initial begin
    int sent, len;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed
    no_idle = 1;
    send_item({8{16'h8000}}, 3'd4, 1);
    send_item({{4{16'h7fff}}, {4{16'h8000}}}, 3'd4, 1);
    send_item({{4{16'h7fff}}, {4{16'h7fff}}}, 3'd4, 1);
    send_item({{4{16'h1234}}, {4{16'h0000}}}, 3'd4, 1);
    send_item({{4{16'h0000}}, {4{16'h4000}}}, 3'd3, 1);
    send_item({8{16'h0000}}, 3'd2, 1);
    send_item({8{16'hffff}}, 3'd0, 1);
    send_item({8{16'h5555}}, 3'd7, 0);
    send_item({{16'h0001, 16'h8000, 16'h7fff, 16'h0001},
               {16'hffff, 16'h7fff, 16'h8000, 16'haaaa}}, 3'd5, 0);
    send_item({{4{16'h4000}}, {4{16'hc000}}}, 3'd1, 1);
    send_item({8{16'h4000}}, 3'd6, 1);
    send_item({{4{16'h7fff}}, {4{16'h3000}}}, 3'd2, 1);
    no_idle = 0;
    sent = 12;
    while (sent < 1150) begin
      if ($urandom_range(0, 15) == 0) no_idle = ~no_idle;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      send_pair(len);
      sent += len;
    end
    s_tvalid <= 0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (tracker.fails == 0 && tracker.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
